>>> hdl/twhbt_pkg.sv
// Shared types and constants for the two-wire handshake byte transfer unit.
package twhbt_pkg;

    // Command codes carried with each line sample.
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_SEND_HS = 2'd1,
        OP_SEND_NH = 2'd2,
        OP_RECV    = 2'd3
    } op_t;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BIT_IDX_W = 3;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;
    localparam logic [BIT_IDX_W-1:0] FIRST_BIT_IDX = 3'd0;

    // One line sample with its command.
    typedef struct packed {
        logic         clock_in;
        logic         data_in;
        logic [7:0]   tx_byte;
        op_t          operation;
    } tick_t;

    // Result of one tick, packed first field in the highest bits.
    typedef struct packed {
        logic         busy_res;
        logic         done_res;
        logic [7:0]   rx_byte;
        logic         clock_drive;
        logic         data_drive;
    } result_t;

endpackage

>>> hdl/twhbt_core.sv
// Line handshake state machine: one tick per enable, result of the tick out.
module twhbt_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  twhbt_pkg::tick_t    tick,
    output twhbt_pkg::result_t  result
);

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_S_CLK_HI    = 4'd1,
        PH_S_CLK_LO    = 4'd2,
        PH_S_DATA_NEXT = 4'd3,
        PH_S_DATA_FIN  = 4'd4,
        PH_R_DATA_LO   = 4'd5,
        PH_R_SAMPLE    = 4'd6,
        PH_R_CLK_CHG   = 4'd7,
        PH_R_DATA_HI   = 4'd8
    } phase_t;

    phase_t                             phase_reg, phase_next;
    twhbt_pkg::op_t                     mode_reg, mode_next;
    logic [twhbt_pkg::BIT_IDX_W-1:0]    bit_count_reg, bit_count_next;
    logic [twhbt_pkg::BYTE_W-1:0]       shift_reg, shift_next;
    logic                               sampled_reg, sampled_next;
    logic                               data_out_reg, data_out_next;
    logic                               clock_out_reg, clock_out_next;
    logic                               done;

    // Next state for one tick of the lines.
    always_comb
    begin
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        sampled_next   = sampled_reg;
        data_out_next  = data_out_reg;
        clock_out_next = clock_out_reg;
        done           = 1'b0;
        unique case (phase_reg)
            PH_S_CLK_HI:
            begin
                // Partner took CLOCK: put the complement on DATA.
                if (tick.clock_in)
                begin
                    data_out_next = ~sampled_reg;
                    phase_next    = PH_S_CLK_LO;
                end
            end
            PH_S_CLK_LO:
            begin
                if (!tick.clock_in)
                begin
                    data_out_next  = 1'b0;
                    clock_out_next = 1'b1;
                    if (bit_count_reg == twhbt_pkg::FIRST_BIT_IDX)
                    begin
                        if (mode_reg == twhbt_pkg::OP_SEND_NH)
                        begin
                            done       = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_S_DATA_FIN;
                        end
                    end
                    else
                    begin
                        phase_next = PH_S_DATA_NEXT;
                    end
                end
            end
            PH_S_DATA_NEXT:
            begin
                // Start the next bit, MSB first.
                if (tick.data_in)
                begin
                    bit_count_next = bit_count_reg - 1'b1;
                    sampled_next   = shift_reg[bit_count_next];
                    data_out_next  = sampled_next;
                    clock_out_next = 1'b0;
                    phase_next     = PH_S_CLK_HI;
                end
            end
            PH_S_DATA_FIN:
            begin
                if (tick.data_in)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_R_DATA_LO:
            begin
                if (!tick.data_in)
                begin
                    clock_out_next = 1'b0;
                    phase_next     = PH_R_SAMPLE;
                end
            end
            PH_R_SAMPLE:
            begin
                // The bit is read from the CLOCK level and enters at the top.
                sampled_next  = tick.clock_in;
                shift_next    = {tick.clock_in, shift_reg[twhbt_pkg::BYTE_W-1:1]};
                data_out_next = 1'b1;
                phase_next    = PH_R_CLK_CHG;
            end
            PH_R_CLK_CHG:
            begin
                if (tick.clock_in != sampled_reg)
                begin
                    data_out_next = 1'b0;
                    phase_next    = PH_R_DATA_HI;
                end
            end
            PH_R_DATA_HI:
            begin
                if (tick.data_in)
                begin
                    clock_out_next = 1'b1;
                    if (bit_count_reg == twhbt_pkg::FIRST_BIT_IDX)
                    begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg - 1'b1;
                        phase_next     = PH_R_DATA_LO;
                    end
                end
            end
            default:
            begin
                // Idle, and any unused code: take a command.
                phase_next = PH_IDLE;
                case (tick.operation) inside
                    twhbt_pkg::OP_SEND_HS, twhbt_pkg::OP_SEND_NH:
                    begin
                        mode_next      = tick.operation;
                        shift_next     = tick.tx_byte;
                        bit_count_next = twhbt_pkg::LAST_BIT_IDX;
                        sampled_next   = tick.tx_byte[twhbt_pkg::LAST_BIT_IDX];
                        data_out_next  = sampled_next;
                        clock_out_next = 1'b0;
                        phase_next     = PH_S_CLK_HI;
                    end
                    twhbt_pkg::OP_RECV:
                    begin
                        mode_next      = twhbt_pkg::OP_RECV;
                        shift_next     = '0;
                        bit_count_next = twhbt_pkg::LAST_BIT_IDX;
                        phase_next     = PH_R_DATA_LO;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        endcase
    end

    // Result fields reflect the state after this tick.
    always_comb
    begin
        result.data_drive  = data_out_next;
        result.clock_drive = clock_out_next;
        result.rx_byte     = (mode_next == twhbt_pkg::OP_RECV) ? shift_next : '0;
        result.done_res    = done;
        result.busy_res    = (phase_next != PH_IDLE);
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            mode_reg      <= twhbt_pkg::OP_NONE;
            bit_count_reg <= twhbt_pkg::LAST_BIT_IDX;
            shift_reg     <= '0;
            sampled_reg   <= 1'b0;
            data_out_reg  <= 1'b0;
            clock_out_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            sampled_reg   <= sampled_next;
            data_out_reg  <= data_out_next;
            clock_out_reg <= clock_out_next;
        end
    end

endmodule

>>> hdl/two_wire_handshake_byte_transfer_unit.sv
// Top level of the two-wire handshake byte transfer unit with stream ports.
// Each input transfer is one sampled tick of the DATA and CLOCK lines plus an optional command
// (honored only when idle), and each yields exactly one result transfer with the line drives,
// received byte, done pulse and busy flag after that tick. The block takes one tick per cycle
// unless the output register is full and stalled: a tick is held in the input register, and
// the handshake state machine updates as the tick moves into the output register.
module two_wire_handshake_byte_transfer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tx_byte[7:0], data_in[8], clock_in[9], zero fill [15:10]
    input  logic [15:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_drive[0], clock_drive[1], rx_byte[9:2], done_res[10], busy_res[11], zero fill [15:12]
    output logic [15:0] m_axis_tdata
);

    logic                   in_valid_reg;
    twhbt_pkg::tick_t       in_tick_reg;
    logic                   out_valid_reg;
    twhbt_pkg::result_t     out_result_reg;
    twhbt_pkg::result_t     step_result;
    logic                   advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_tick_reg.operation <= twhbt_pkg::op_t'(s_axis_tuser);
            in_tick_reg.tx_byte   <= s_axis_tdata[7:0];
            in_tick_reg.data_in   <= s_axis_tdata[8];
            in_tick_reg.clock_in  <= s_axis_tdata[9];
        end
    end

    twhbt_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .tick   (in_tick_reg),
        .result (step_result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_result_reg};

endmodule

>>> hdl/twhbt_checker.sv
// Port-level checks for the two-wire handshake byte transfer unit, bound to the top level.
module twhbt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Input stalls only when the output side is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // A new result follows an input transfer through the input and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input transfer");

    // A completed byte leaves the unit idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> !m_axis_tdata[11])
        else $error("done with busy still set");

    // Padding bits stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'b0000)
        else $error("output padding not zero");

endmodule

bind two_wire_handshake_byte_transfer_unit twhbt_checker u_twhbt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
